[design/ccc_pkg.sv]
// ----------------------------------------------------------------------------
// ccc_pkg: shared types, constants and functions
// Mode codes, field widths, the cell control struct and the calendar functions
// used by the calendar clock counter cells.
// ----------------------------------------------------------------------------
package ccc_pkg;

    // Item modes
    typedef enum logic [1:0] {
        MODE_TICK     = 2'd0,
        MODE_SET_ALL  = 2'd1,
        MODE_SET_DATE = 2'd2,
        MODE_SET_TIME = 2'd3
    } mode_t;

    // Width of one counter cell, wide enough for minutes and seconds
    localparam int CELL_W = 6;

    typedef logic [CELL_W-1:0] cell_val_t;
    typedef logic [15:0]       year_t;

    // Control handed to a cell: carry in from its neighbor (the tick for the second cell) and a load strobe
    typedef struct packed {
        logic inc;
        logic load;
    } cell_ctrl_t;

    // Cell limits
    localparam cell_val_t SEC_LAST   = 6'd59;
    localparam cell_val_t MIN_LAST   = 6'd59;
    localparam cell_val_t HOUR_LAST  = 6'd23;
    localparam cell_val_t MONTH_LAST = 6'd12;
    localparam cell_val_t BASE_ZERO  = 6'd0;
    localparam cell_val_t BASE_ONE   = 6'd1;

    // Reset date
    localparam year_t YEAR_AT_RESET = 16'd2026;

    // Inverse of 25 modulo 2^16 and the largest product of a multiple of 25
    localparam logic [15:0] INV25     = 16'd23593;
    localparam logic [15:0] DIV25_MAX = 16'd2621;

    // Gregorian leap test; divisibility by 25 via multiply by modular inverse
    function automatic logic is_leap(input year_t y);
        logic [31:0] prod;
        logic        div25;
        logic        div4;
        logic        div16;
        prod  = 32'(y) * 32'(INV25);
        div25 = (prod[15:0] <= DIV25_MAX);
        div4  = (y[1:0] == 2'd0);
        div16 = (y[3:0] == 4'd0);
        return div4 && (!div25 || div16);
    endfunction

    // Last day of a month
    function automatic cell_val_t days_in_month(input cell_val_t m, input logic leap);
        cell_val_t d;
        unique case (m)
            6'd2:                     d = leap ? 6'd29 : 6'd28;
            6'd4, 6'd6, 6'd9, 6'd11:  d = 6'd30;
            default:                  d = 6'd31;
        endcase
        return d;
    endfunction

endpackage

[design/calendar_clock_counter_unit.sv]
// ----------------------------------------------------------------------------
// calendar_clock_counter_unit: Gregorian real-time clock and calendar
// The result beat for an item is valid the cycle after it is taken.
// One item per cycle while the output does not stall; the carry ripple through
// the cell row is combinational, and the output beat is the field registers.
// Reset: 2026-01-01 00:00:00, no result pending.
// ----------------------------------------------------------------------------
module calendar_clock_counter_unit (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  mode,
    input  logic [15:0] set_year,
    input  logic [3:0]  set_month,
    input  logic [4:0]  set_day,
    input  logic [4:0]  set_hour,
    input  logic [5:0]  set_minute,
    input  logic [5:0]  set_second,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [15:0] year_out,
    output logic [3:0]  month_out,
    output logic [4:0]  day_out,
    output logic [4:0]  hour_out,
    output logic [5:0]  minute_out,
    output logic [5:0]  second_out,
    output logic        rejected
);

    logic                out_valid_reg;
    logic                out_valid_next;
    logic                rejected_reg;
    logic                rejected_next;
    logic                accept;
    logic                is_tick;
    logic                use_date;
    logic                use_time;
    logic                date_ok;
    logic                time_ok;
    logic                rej;
    logic                ld_date;
    logic                ld_time;
    ccc_pkg::mode_t      mode_in;

    ccc_pkg::cell_ctrl_t sec_ctrl;
    ccc_pkg::cell_ctrl_t min_ctrl;
    ccc_pkg::cell_ctrl_t hour_ctrl;
    ccc_pkg::cell_ctrl_t day_ctrl;
    ccc_pkg::cell_ctrl_t month_ctrl;
    ccc_pkg::cell_ctrl_t year_ctrl;

    ccc_pkg::cell_val_t  sec_val;
    ccc_pkg::cell_val_t  min_val;
    ccc_pkg::cell_val_t  hour_val;
    ccc_pkg::cell_val_t  day_val;
    ccc_pkg::cell_val_t  month_val;
    ccc_pkg::cell_val_t  day_last;
    ccc_pkg::year_t      year_val;
    logic                leap;
    logic                sec_carry;
    logic                min_carry;
    logic                hour_carry;
    logic                day_carry;
    logic                month_carry;

    // The field registers are the output beat, so hold them while it stalls
    assign in_stall = out_valid_reg && out_stall;
    assign accept   = in_valid && !in_stall;
    assign mode_in  = ccc_pkg::mode_t'(mode);

    // Decode and range checks
    always_comb
    begin
        is_tick  = (mode_in == ccc_pkg::MODE_TICK);
        use_date = (mode_in == ccc_pkg::MODE_SET_ALL) || (mode_in == ccc_pkg::MODE_SET_DATE);
        use_time = (mode_in == ccc_pkg::MODE_SET_ALL) || (mode_in == ccc_pkg::MODE_SET_TIME);
        date_ok  = (set_month >= 4'd1) && (set_month <= 4'd12) && (set_day != 5'd0);
        time_ok  = (set_hour <= 5'd23) && (set_minute <= 6'd59) && (set_second <= 6'd59);
        rej      = !is_tick && ((use_date && !date_ok) || (use_time && !time_ok));
        ld_date  = accept && !is_tick && use_date && !rej;
        ld_time  = accept && !is_tick && use_time && !rej;
    end

    // Carry chain controls between neighboring cells
    always_comb
    begin
        day_last        = ccc_pkg::days_in_month(month_val, leap);
        sec_ctrl.inc    = accept && is_tick;
        sec_ctrl.load   = ld_time;
        min_ctrl.inc    = sec_carry;
        min_ctrl.load   = ld_time;
        hour_ctrl.inc   = min_carry;
        hour_ctrl.load  = ld_time;
        day_ctrl.inc    = hour_carry;
        day_ctrl.load   = ld_date;
        month_ctrl.inc  = day_carry;
        month_ctrl.load = ld_date;
        year_ctrl.inc   = month_carry;
        year_ctrl.load  = ld_date;
    end

    // Cell row: second, minute, hour, day, month, year
    ccc_cell u_sec (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctrl     (sec_ctrl),
        .load_val (set_second),
        .last_val (ccc_pkg::SEC_LAST),
        .base_val (ccc_pkg::BASE_ZERO),
        .rst_val  (ccc_pkg::BASE_ZERO),
        .val      (sec_val),
        .carry    (sec_carry)
    );

    ccc_cell u_min (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctrl     (min_ctrl),
        .load_val (set_minute),
        .last_val (ccc_pkg::MIN_LAST),
        .base_val (ccc_pkg::BASE_ZERO),
        .rst_val  (ccc_pkg::BASE_ZERO),
        .val      (min_val),
        .carry    (min_carry)
    );

    ccc_cell u_hour (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctrl     (hour_ctrl),
        .load_val ({1'b0, set_hour}),
        .last_val (ccc_pkg::HOUR_LAST),
        .base_val (ccc_pkg::BASE_ZERO),
        .rst_val  (ccc_pkg::BASE_ZERO),
        .val      (hour_val),
        .carry    (hour_carry)
    );

    ccc_cell u_day (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctrl     (day_ctrl),
        .load_val ({1'b0, set_day}),
        .last_val (day_last),
        .base_val (ccc_pkg::BASE_ONE),
        .rst_val  (ccc_pkg::BASE_ONE),
        .val      (day_val),
        .carry    (day_carry)
    );

    ccc_cell u_month (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctrl     (month_ctrl),
        .load_val ({2'b00, set_month}),
        .last_val (ccc_pkg::MONTH_LAST),
        .base_val (ccc_pkg::BASE_ONE),
        .rst_val  (ccc_pkg::BASE_ONE),
        .val      (month_val),
        .carry    (month_carry)
    );

    ccc_year_cell u_year (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctrl     (year_ctrl),
        .load_val (set_year),
        .year     (year_val),
        .leap     (leap)
    );

    // Output beat control
    always_comb
    begin
        rejected_next  = accept ? rej : rejected_reg;
        out_valid_next = accept || (out_valid_reg && out_stall);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            rejected_reg  <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            rejected_reg  <= rejected_next;
        end
    end

    assign out_valid  = out_valid_reg;
    assign rejected   = rejected_reg;
    assign year_out   = year_val;
    assign month_out  = month_val[3:0];
    assign day_out    = day_val[4:0];
    assign hour_out   = hour_val[4:0];
    assign minute_out = min_val;
    assign second_out = sec_val;

endmodule

[design/ccc_cell.sv]
// ----------------------------------------------------------------------------
// ccc_cell: one wrapping counter cell
// Holds one time or date field, counts on carry in, wraps to its base value
// past its last value and hands a carry to the next cell.
// ----------------------------------------------------------------------------
module ccc_cell (
    input  logic               clk,
    input  logic               rst_n,
    input  ccc_pkg::cell_ctrl_t ctrl,
    input  ccc_pkg::cell_val_t load_val,
    input  ccc_pkg::cell_val_t last_val,
    input  ccc_pkg::cell_val_t base_val,
    input  ccc_pkg::cell_val_t rst_val,
    output ccc_pkg::cell_val_t val,
    output logic               carry
);

    ccc_pkg::cell_val_t val_reg;
    ccc_pkg::cell_val_t val_next;

    // Wrap at or past the last value (a day loaded past month end included)
    assign carry = ctrl.inc && (val_reg >= last_val);

    // Next value
    always_comb
    begin
        priority if (ctrl.load)
        begin
            val_next = load_val;
        end
        else if (carry)
        begin
            val_next = base_val;
        end
        else if (ctrl.inc)
        begin
            val_next = val_reg + ccc_pkg::CELL_W'(1);
        end
        else
        begin
            val_next = val_reg;
        end
    end

    // Field register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            val_reg <= rst_val;
        end
        else
        begin
            val_reg <= val_next;
        end
    end

    assign val = val_reg;

endmodule

[design/ccc_year_cell.sv]
// ----------------------------------------------------------------------------
// ccc_year_cell: year cell at the end of the chain
// Counts years modulo 2^16 and keeps a leap flag for the current year, which
// the day cell uses for the length of February.
// ----------------------------------------------------------------------------
module ccc_year_cell (
    input  logic                clk,
    input  logic                rst_n,
    input  ccc_pkg::cell_ctrl_t ctrl,
    input  ccc_pkg::year_t      load_val,
    output ccc_pkg::year_t      year,
    output logic                leap
);

    ccc_pkg::year_t year_reg;
    ccc_pkg::year_t year_next;
    logic           leap_reg;
    logic           leap_next;

    // Next year and its leap flag
    always_comb
    begin
        priority if (ctrl.load)
        begin
            year_next = load_val;
        end
        else if (ctrl.inc)
        begin
            year_next = year_reg + 16'd1;
        end
        else
        begin
            year_next = year_reg;
        end
        leap_next = ccc_pkg::is_leap(year_next);
    end

    // Year and leap registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            year_reg <= ccc_pkg::YEAR_AT_RESET;
            leap_reg <= ccc_pkg::is_leap(ccc_pkg::YEAR_AT_RESET);
        end
        else
        begin
            year_reg <= year_next;
            leap_reg <= leap_next;
        end
    end

    assign year = year_reg;
    assign leap = leap_reg;

endmodule
